// ===== rtl/mbps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants of the masked byte pattern search
// Sizes of the pattern and window, configuration register codes and the
// control bundle that drives one window cell.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam int MAX_PATTERN   = 16;
	localparam int PATTERN_BYTES = 16;
	localparam int LEN_CAP       = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
	localparam int IDX_W         = $clog2(PATTERN_BYTES);
	localparam int LEN_W         = 5;
	localparam int ADDR_W        = 64;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_IDX_W     = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_BYTE_MASK      = 3'd2,
		REG_PATTERN_LENGTH = 3'd3,
		REG_BASE_ADDRESS   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic       shift;
		logic       care;
		logic [7:0] pat;
	} cell_ctrl_t;

endpackage

// ===== rtl/mbps_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_byte_if: input channel of the pattern search
// One item is one byte of the scanned region with its end-of-region flag.
// ----------------------------------------------------------------------------
interface mbps_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/mbps_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_result_if: result channel of the pattern search
// One item reports a match address or that the region held no match.
// ----------------------------------------------------------------------------
interface mbps_result_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [63:0] match_address;

	modport source (output valid, output found, output match_address, input ready);
	modport sink (input valid, input found, input match_address, output ready);
endinterface

// ===== rtl/mbps_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_cell: one position of the sliding byte window
// Holds one window byte, takes the byte on its input on each shift and flags
// whether the byte it is about to hold satisfies its pattern byte.
// ----------------------------------------------------------------------------
module mbps_cell (
	input  logic                clk,
	input  mbps_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]          d_in,
	output logic [7:0]          byte_q,
	output logic                hit
);
	import mbps_pkg::*;

	assign hit = !ctrl.care || (d_in == ctrl.pat);

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			byte_q <= d_in;
		end
	end
endmodule

// ===== rtl/masked_byte_pattern_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_search: masked byte signature scan over a byte stream
// Timing: a result is presented in the cycle after the byte that causes it.
// Throughput: one byte per cycle, as the window compare of the cell chain is
// combinational; a waiting result stops input until it is taken.
// Reset clears the region state and loads the register reset values; the
// window bytes are not cleared, as positions not yet filled never count to a match.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
	mbps_byte_if.sink                           scan,
	mbps_result_if.source                       result
);
	import mbps_pkg::*;

	logic [63:0]             pattern_low_q;
	logic [63:0]             pattern_high_q;
	logic [PATTERN_BYTES-1:0] byte_mask_q;
	logic [LEN_W-1:0]        pattern_length_q;
	logic [ADDR_W-1:0]       base_address_q;

	logic [ADDR_W-1:0]       pos_q;
	logic [LEN_W-1:0]        cnt_q;
	logic                    done_q;

	logic                    out_valid_q;
	logic                    found_q;
	logic [ADDR_W-1:0]       offset_q;

	logic                    accept;
	logic                    emit;
	logic [LEN_W-1:0]        n_eff;
	logic [LEN_W-1:0]        cnt_nx;
	logic [ADDR_W-1:0]       offset_nx;
	logic [8*PATTERN_BYTES-1:0] pat_all;
	logic                    match;

	cell_ctrl_t              ctrl   [LEN_CAP];
	logic [7:0]              win    [LEN_CAP];
	logic [7:0]              d_cell [LEN_CAP];
	logic [LEN_CAP-1:0]      hits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			byte_mask_q      <= '0;
			pattern_length_q <= LEN_W'(1);
			base_address_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:    pattern_low_q    <= cfg_data[63:0];
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data[63:0];
				REG_BYTE_MASK:      byte_mask_q      <= cfg_data[PATTERN_BYTES-1:0];
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_W-1:0];
				REG_BASE_ADDRESS:   base_address_q   <= cfg_data[ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (pattern_length_q == '0) begin
			n_eff = LEN_W'(1);
		end else if (pattern_length_q > LEN_W'(LEN_CAP)) begin
			n_eff = LEN_W'(LEN_CAP);
		end else begin
			n_eff = pattern_length_q;
		end
	end

	assign pat_all = {pattern_high_q, pattern_low_q};
	assign accept  = scan.valid && scan.ready;

	for (genvar k = 0; k < LEN_CAP; k++) begin : g_cell
		logic [LEN_W-1:0] idx_full;
		logic [IDX_W-1:0] idx;

		assign idx_full = n_eff - LEN_W'(1) - LEN_W'(k);
		assign idx      = idx_full[IDX_W-1:0];

		assign ctrl[k].shift = accept && !done_q;
		assign ctrl[k].care  = (LEN_W'(k) < n_eff) && byte_mask_q[idx];
		assign ctrl[k].pat   = pat_all[idx*8 +: 8];

		if (k == 0) begin : g_head
			assign d_cell[k] = scan.data_byte;
		end else begin : g_body
			assign d_cell[k] = win[k-1];
		end

		mbps_cell u_cell (
			.clk    (clk),
			.ctrl   (ctrl[k]),
			.d_in   (d_cell[k]),
			.byte_q (win[k]),
			.hit    (hits[k])
		);
	end

	assign cnt_nx    = (cnt_q == LEN_W'(LEN_CAP)) ? cnt_q : cnt_q + LEN_W'(1);
	assign match     = (&hits) && (cnt_nx >= n_eff);
	assign offset_nx = pos_q - ADDR_W'(n_eff - LEN_W'(1));
	assign emit      = accept && !done_q && (match || scan.last_byte);

	assign scan.ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			cnt_q       <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (done_q) begin
					if (scan.last_byte) begin
						pos_q  <= '0;
						cnt_q  <= '0;
						done_q <= 1'b0;
					end
				end else if (match || scan.last_byte) begin
					if (scan.last_byte) begin
						pos_q  <= '0;
						cnt_q  <= '0;
						done_q <= 1'b0;
					end else begin
						pos_q  <= pos_q + ADDR_W'(1);
						cnt_q  <= cnt_nx;
						done_q <= 1'b1;
					end
				end else begin
					pos_q <= pos_q + ADDR_W'(1);
					cnt_q <= cnt_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_q  <= match;
			offset_q <= offset_nx;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.found         = found_q;
	assign result.match_address = found_q ? base_address_q + offset_q : '0;

	// A region is marked done only together with a found result item.
	a_done_with_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> (out_valid_q && found_q))
		else $error("match flag set without a found item");

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LEN_W'(LEN_CAP))
		else $error("fill count above window depth");

	a_cnt_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (pos_q == '0))
		else $error("fill count and byte position disagree");

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && scan.last_byte) |=> ((cnt_q == '0) && !done_q))
		else $error("region state not cleared after the final byte");

endmodule
